FILE: hdl/bdp_pkg.sv
`default_nettype none

package bdp_pkg;

  // Default sizes of the predictor tables.
  localparam int DEF_COUNTER_ENTRIES = 4096;
  localparam int DEF_HISTORY_LEN     = 16;
  localparam int DEF_PERCEPTRON_ROWS = 256;
  localparam int DEF_WEIGHT_BITS     = 8;

  // Fixed field widths.
  localparam int PC_W       = 32;
  localparam int OFFSET_W   = 21;
  localparam int MODE_W     = 3;
  localparam int THR_W      = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 2'd1;

  // Predictor modes.
  localparam logic [MODE_W-1:0] MODE_NEVER    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ALWAYS   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_BACKWARD = 3'd2;
  localparam logic [MODE_W-1:0] MODE_COUNTER  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_PERCEPT  = 3'd4;

  localparam logic [MODE_W-1:0] MODE_RESET = MODE_COUNTER;
  localparam logic [THR_W-1:0]  THR_RESET  = 12'd30;

  // Item function codes.
  localparam logic FUNC_PREDICT = 1'b0;
  localparam logic FUNC_UPDATE  = 1'b1;

  // Two-bit counter codes.
  localparam logic [1:0] CTR_STRONG_NT = 2'd0;
  localparam logic [1:0] CTR_WEAK_T    = 2'd2;
  localparam logic [1:0] CTR_STRONG_T  = 2'd3;

  // Sequencer states, one-hot.
  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_MOD   = 6'b000100,
    ST_ADDR  = 6'b001000,
    ST_CWB   = 6'b010000,
    ST_WALK  = 6'b100000
  } state_t;

endpackage

`default_nettype wire

FILE: hdl/branch_direction_predictor.sv
`default_nettype none

// Channel    Signals                                   Handshake
// ---------  ----------------------------------------  ------------------------------
// item in    func, pc, offset, taken                   beat when start && !busy
// result     predict_taken                             beat when done (one cycle)
// config     cfg_index, cfg_data                       beat when cfg_valid && cfg_ready
//
// After reset the block sweeps both tables with busy high, over max(COUNTER_ENTRIES,
// PERCEPTRON_ROWS*(HISTORY_LEN+1)) addresses. Modes never, always, backward and unused
// answer in the cycle after the accept, and counter mode goes through ST_ADDR and ST_CWB
// for the registered read of the counter memory. Perceptron predicts and training updates
// go through ST_ADDR and ST_WALK: the shared adder walks the bias and every history weight,
// one per cycle, through the weight memory. An update that needs no training only shifts
// the history, answering from ST_ADDR. A modulus that is not a power of two adds ST_MOD,
// a restoring remainder step per pc bit.
// The receiver cannot stall: every result is a one-cycle strobe on done.

module branch_direction_predictor
  import bdp_pkg::*;
#(
  parameter int COUNTER_ENTRIES = DEF_COUNTER_ENTRIES,
  parameter int HISTORY_LEN     = DEF_HISTORY_LEN,
  parameter int PERCEPTRON_ROWS = DEF_PERCEPTRON_ROWS,
  parameter int WEIGHT_BITS     = DEF_WEIGHT_BITS
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  output logic                         busy,
  input  wire                          func,
  input  wire         [PC_W-1:0]       pc,
  input  wire  signed [OFFSET_W-1:0]   offset,
  input  wire                          taken,
  output logic                         done,
  output logic                         predict_taken,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire         [CFG_IDX_W-1:0]  cfg_index,
  input  wire         [CFG_DATA_W-1:0] cfg_data
);

  // Derived sizes.
  localparam int ROW_LEN  = HISTORY_LEN + 1;
  localparam int WDEPTH   = PERCEPTRON_ROWS * ROW_LEN;
  localparam int CLR_LEN  = (COUNTER_ENTRIES > WDEPTH) ? COUNTER_ENTRIES : WDEPTH;
  localparam int CLR_W    = $clog2(CLR_LEN);
  localparam int CIDX_W   = $clog2(COUNTER_ENTRIES);
  localparam int WADDR_W  = $clog2(WDEPTH);
  localparam int RIDX_W   = (PERCEPTRON_ROWS > 1) ? $clog2(PERCEPTRON_ROWS) : 1;
  localparam int MAX_MOD  = (COUNTER_ENTRIES > PERCEPTRON_ROWS) ? COUNTER_ENTRIES
                                                                 : PERCEPTRON_ROWS;
  localparam int MOD_W    = $clog2(MAX_MOD) + 1;
  localparam int IDX_W    = $clog2(ROW_LEN + 1);
  localparam int SUM_W    = WEIGHT_BITS + $clog2(ROW_LEN);
  localparam int CMP_W    = (SUM_W > THR_W) ? SUM_W : THR_W;
  localparam int WX_W     = WEIGHT_BITS + 2;
  localparam bit CTR_POW2 = (COUNTER_ENTRIES & (COUNTER_ENTRIES - 1)) == 0;
  localparam bit ROW_POW2 = (PERCEPTRON_ROWS & (PERCEPTRON_ROWS - 1)) == 0;

  localparam logic signed [WX_W-1:0] WMAX_X = WX_W'((1 << (WEIGHT_BITS - 1)) - 1);
  localparam logic signed [WX_W-1:0] WMIN_X = -WMAX_X - WX_W'(1);

  // Configuration registers. Writes are always taken.
  logic [MODE_W-1:0] mode;
  logic [THR_W-1:0]  thr;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_RESET;
      thr  <= THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MODE:   mode <= cfg_data[MODE_W-1:0];
        CFG_THRESH: thr  <= cfg_data[THR_W-1:0];
        default:    ;
      endcase
    end
  end

  // Sequencer and item registers.
  state_t state;
  logic [CLR_W-1:0]    clr_cnt;
  logic                op_upd;
  logic                op_taken;
  logic [PC_W-1:0]     op_pc;
  logic                op_train;
  logic [MOD_W-1:0]    rem;
  logic [4:0]          bit_cnt;
  logic [CIDX_W-1:0]   cidx;
  logic [WADDR_W-1:0]  wbase;
  logic [IDX_W-1:0]    rd_idx;
  logic [IDX_W-1:0]    didx;
  logic                dvalid;
  logic signed [SUM_W-1:0] acc;
  logic signed [SUM_W-1:0] last_sum;
  logic [HISTORY_LEN-1:0]  hist_dirs;
  logic [HISTORY_LEN-1:0]  hist_valid;

  assign busy = (state != ST_IDLE);

  // Memories.
  logic [1:0]                    ctr_mem [COUNTER_ENTRIES];
  logic signed [WEIGHT_BITS-1:0] wmem    [WDEPTH];
  logic [1:0]                    ctr_rdata;
  logic signed [WEIGHT_BITS-1:0] w_rdata;
  logic [CIDX_W-1:0]             ctr_raddr;
  logic                          ctr_we;
  logic [CIDX_W-1:0]             ctr_waddr;
  logic [1:0]                    ctr_wdata;
  logic [WADDR_W-1:0]            w_raddr;
  logic                          w_we;
  logic [WADDR_W-1:0]            w_waddr;
  logic signed [WEIGHT_BITS-1:0] w_wdata;

  always_ff @(posedge clk) begin
    if (ctr_we) begin
      ctr_mem[ctr_waddr] <= ctr_wdata;
    end
    ctr_rdata <= ctr_mem[ctr_raddr];
  end

  always_ff @(posedge clk) begin
    if (w_we) begin
      wmem[w_waddr] <= w_wdata;
    end
    w_rdata <= wmem[w_raddr];
  end

  // Index computation. A power-of-two modulus is a mask; otherwise the remainder
  // is built one pc bit per cycle with a shift, compare and subtract.
  logic [PC_W-1:0]  ctr_masked;
  logic [PC_W-1:0]  row_masked;
  logic             mod_pow2;
  logic [MOD_W-1:0] divisor;
  logic [MOD_W-1:0] rem_shift;
  logic [MOD_W-1:0] rem_next;

  assign ctr_masked = pc & PC_W'(COUNTER_ENTRIES - 1);
  assign row_masked = pc & PC_W'(PERCEPTRON_ROWS - 1);
  assign mod_pow2   = (mode == MODE_COUNTER) ? CTR_POW2 : ROW_POW2;
  assign divisor    = (mode == MODE_COUNTER) ? MOD_W'(COUNTER_ENTRIES)
                                             : MOD_W'(PERCEPTRON_ROWS);
  assign rem_shift  = {rem[MOD_W-2:0], op_pc[bit_cnt]};
  assign rem_next   = (rem_shift >= divisor) ? (rem_shift - divisor) : rem_shift;

  // Training decision from the sum of the latest predict.
  logic [SUM_W-1:0] mag;
  logic             train_now;

  assign mag       = last_sum[SUM_W-1] ? SUM_W'(-last_sum) : SUM_W'(last_sum);
  assign train_now = ((!last_sum[SUM_W-1]) != taken) || (CMP_W'(mag) <= CMP_W'(thr));

  // Weight walk: the shared adder takes one weight per cycle.
  logic                    issue;
  logic [IDX_W-1:0]        hpos;
  logic [HISTORY_LEN-1:0]  hv_shift;
  logic [HISTORY_LEN-1:0]  hd_shift;
  logic                    h_valid;
  logic                    h_dir;
  logic                    is_bias;
  logic                    walk_last;
  logic signed [WX_W-1:0]  w_ext;
  logic signed [WX_W-1:0]  term;
  logic signed [WX_W-1:0]  delta;
  logic signed [WX_W-1:0]  w_sum;
  logic signed [WEIGHT_BITS-1:0] w_next;
  logic signed [SUM_W-1:0] acc_next;
  logic [1:0]              ctr_next;
  logic                    result_now;

  assign issue     = (state == ST_WALK) && (rd_idx <= IDX_W'(HISTORY_LEN));
  assign hpos      = didx - IDX_W'(1);
  assign hv_shift  = hist_valid >> hpos;
  assign hd_shift  = hist_dirs >> hpos;
  assign h_valid   = hv_shift[0];
  assign h_dir     = hd_shift[0];
  assign is_bias   = (didx == '0);
  assign walk_last = dvalid && (didx == IDX_W'(HISTORY_LEN));
  assign w_ext     = WX_W'(w_rdata);

  always_comb begin
    if (is_bias) begin
      term  = w_ext;
      delta = op_taken ? WX_W'(1) : -WX_W'(1);
    end else if (h_valid) begin
      term  = h_dir ? w_ext : -w_ext;
      delta = (h_dir == op_taken) ? WX_W'(1) : -WX_W'(1);
    end else begin
      term  = '0;
      delta = '0;
    end
    w_sum = w_ext + delta;
    if (w_sum > WMAX_X) begin
      w_next = WEIGHT_BITS'(WMAX_X);
    end else if (w_sum < WMIN_X) begin
      w_next = WEIGHT_BITS'(WMIN_X);
    end else begin
      w_next = WEIGHT_BITS'(w_sum);
    end
    acc_next = acc + SUM_W'(term);
  end

  always_comb begin
    if (op_taken) begin
      ctr_next = (ctr_rdata == CTR_STRONG_T) ? ctr_rdata : ctr_rdata + 2'd1;
    end else begin
      ctr_next = (ctr_rdata == CTR_STRONG_NT) ? ctr_rdata : ctr_rdata - 2'd1;
    end
  end

  // The cycle in which an item finishes; done follows it by one register.
  always_comb begin
    case (state)
      ST_IDLE:  result_now = start && !(mode inside {MODE_COUNTER, MODE_PERCEPT});
      ST_ADDR:  result_now = (mode != MODE_COUNTER) && op_upd && !op_train;
      ST_CWB:   result_now = 1'b1;
      ST_WALK:  result_now = walk_last;
      default:  result_now = 1'b0;
    endcase
  end

  // Memory port selection. The clearing sweep owns both write ports after reset.
  always_comb begin
    ctr_raddr = rem[CIDX_W-1:0];
    w_raddr   = wbase + WADDR_W'(rd_idx);
    ctr_we    = 1'b0;
    ctr_waddr = cidx;
    ctr_wdata = ctr_next;
    w_we      = 1'b0;
    w_waddr   = wbase + WADDR_W'(didx);
    w_wdata   = w_next;
    if (state == ST_CLEAR) begin
      ctr_we    = (32'(clr_cnt) < 32'(COUNTER_ENTRIES));
      ctr_waddr = clr_cnt[CIDX_W-1:0];
      ctr_wdata = CTR_WEAK_T;
      w_we      = (32'(clr_cnt) < 32'(WDEPTH));
      w_waddr   = clr_cnt[WADDR_W-1:0];
      w_wdata   = '0;
    end else if (state == ST_CWB) begin
      ctr_we = op_upd;
    end else if (state == ST_WALK) begin
      w_we = dvalid && op_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_cnt    <= '0;
      done       <= 1'b0;
      dvalid     <= 1'b0;
      hist_dirs  <= '0;
      hist_valid <= '0;
      last_sum   <= '0;
    end else begin
      done   <= result_now;
      dvalid <= issue;
      didx   <= rd_idx;
      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + CLR_W'(1);
          if (clr_cnt == CLR_W'(CLR_LEN - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            op_upd   <= (func == FUNC_UPDATE);
            op_taken <= taken;
            op_pc    <= pc;
            op_train <= train_now;
            bit_cnt  <= 5'(PC_W - 1);
            if (mode inside {MODE_COUNTER, MODE_PERCEPT}) begin
              if (mod_pow2) begin
                rem   <= (mode == MODE_COUNTER) ? MOD_W'(ctr_masked) : MOD_W'(row_masked);
                state <= ST_ADDR;
              end else begin
                rem   <= '0;
                state <= ST_MOD;
              end
            end else begin
              // Simple modes answer at once; updates change nothing.
              if (func == FUNC_UPDATE) begin
                predict_taken <= 1'b0;
              end else begin
                case (mode)
                  MODE_ALWAYS:   predict_taken <= 1'b1;
                  MODE_BACKWARD: predict_taken <= offset[OFFSET_W-1];
                  default:       predict_taken <= 1'b0;
                endcase
              end
            end
          end
        end
        ST_MOD: begin
          rem     <= rem_next;
          bit_cnt <= bit_cnt - 5'd1;
          if (bit_cnt == 5'd0) begin
            state <= ST_ADDR;
          end
        end
        ST_ADDR: begin
          if (mode == MODE_COUNTER) begin
            // The counter read is issued here and returns next cycle.
            cidx  <= rem[CIDX_W-1:0];
            state <= ST_CWB;
          end else begin
            wbase  <= WADDR_W'(32'(rem[RIDX_W-1:0]) * ROW_LEN);
            acc    <= '0;
            rd_idx <= '0;
            if (!op_upd || op_train) begin
              state <= ST_WALK;
            end else begin
              // Confident and correct: only the history moves.
              hist_dirs     <= (hist_dirs >> 1)
                               | (HISTORY_LEN'(op_taken) << (HISTORY_LEN - 1));
              hist_valid    <= (hist_valid >> 1)
                               | (HISTORY_LEN'(1) << (HISTORY_LEN - 1));
              predict_taken <= 1'b0;
              state         <= ST_IDLE;
            end
          end
        end
        ST_CWB: begin
          predict_taken <= op_upd ? 1'b0 : ctr_rdata[1];
          state         <= ST_IDLE;
        end
        ST_WALK: begin
          if (issue) begin
            rd_idx <= rd_idx + IDX_W'(1);
          end
          if (dvalid) begin
            acc <= acc_next;
          end
          if (walk_last) begin
            state <= ST_IDLE;
            if (op_upd) begin
              hist_dirs     <= (hist_dirs >> 1)
                               | (HISTORY_LEN'(op_taken) << (HISTORY_LEN - 1));
              hist_valid    <= (hist_valid >> 1)
                               | (HISTORY_LEN'(1) << (HISTORY_LEN - 1));
              predict_taken <= 1'b0;
            end else begin
              last_sum      <= acc_next;
              predict_taken <= !acc_next[SUM_W-1];
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // An accepted item either answers next cycle or keeps the block busy.
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (done || busy))
    else $error("accepted item neither answered nor held busy");

  // Weight data is only consumed while walking a row.
  a_dvalid_walk: assert property (@(posedge clk) disable iff (rst)
    dvalid |-> (state == ST_WALK))
    else $error("weight data returned outside the walk");

  // No result comes out while the tables are being swept.
  a_no_done_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !done)
    else $error("result during clearing sweep");

  // History entries only ever fill, never empty.
  a_hist_fill: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> ($countones(hist_valid) >= $countones($past(hist_valid))))
    else $error("history valid bits decreased");

endmodule

`default_nettype wire

FILE: bench/bdp_checker.sv
// Watches the item, result and register channels of the branch direction
// predictor, keeps its own copy of the predictor state, and checks every
// direction strobe against the oldest outstanding prediction.
module bdp_checker
  import bdp_pkg::*;
(
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  input  wire                          busy,
  input  wire                          func,
  input  wire         [PC_W-1:0]       pc,
  input  wire  signed [OFFSET_W-1:0]   offset,
  input  wire                          taken,
  input  wire                          done,
  input  wire                          predict_taken,
  input  wire                          cfg_valid,
  input  wire                          cfg_ready,
  input  wire         [CFG_IDX_W-1:0]  cfg_index,
  input  wire         [CFG_DATA_W-1:0] cfg_data,
  output int                           fail_count,
  output int                           waiting,
  output int                           checked
);

  localparam int HIST  = DEF_HISTORY_LEN;
  localparam int ROWS  = DEF_PERCEPTRON_ROWS;
  localparam int WB    = DEF_WEIGHT_BITS;
  localparam int W_MAX = (1 << (WB - 1)) - 1;
  localparam int W_MIN = -(1 << (WB - 1));
  localparam logic [PC_W-1:0] CTR_MOD = DEF_COUNTER_ENTRIES;
  localparam logic [PC_W-1:0] ROW_MOD = ROWS;

  typedef struct {
    logic            upd;
    logic [PC_W-1:0] addr;
    logic            dir;
  } direction_t;

  logic [MODE_W-1:0]    mode_reg;
  logic [THR_W-1:0]     thr_reg;
  logic [1:0]           counters [DEF_COUNTER_ENTRIES];
  logic signed [WB-1:0] weights [ROWS][HIST+1];
  logic [HIST-1:0]      hist_dir;
  logic [HIST-1:0]      hist_val;
  int                   last_sum;
  direction_t           expected_dirs [$];

  function automatic void clear_predictor();
    mode_reg = MODE_RESET;
    thr_reg  = THR_RESET;
    for (int i = 0; i < DEF_COUNTER_ENTRIES; i++) counters[i] = CTR_WEAK_T;
    for (int r = 0; r < ROWS; r++)
      for (int k = 0; k <= HIST; k++) weights[r][k] = '0;
    hist_dir = '0;
    hist_val = '0;
    last_sum = 0;
  endfunction

  // History entry as a multiplier: +1 taken, -1 not taken, 0 still empty.
  function automatic int hist_weight(int i);
    if (!hist_val[i]) return 0;
    return hist_dir[i] ? 1 : -1;
  endfunction

  function automatic logic signed [WB-1:0] clip(int v);
    if (v > W_MAX) return WB'(W_MAX);
    if (v < W_MIN) return WB'(W_MIN);
    return WB'(v);
  endfunction

  function automatic int row_sum(int row);
    int s;
    s = int'(weights[row][0]);
    for (int i = 0; i < HIST; i++) s += weights[row][i + 1] * hist_weight(i);
    return s;
  endfunction

  // Training always judges the sum of the most recent perceptron predict,
  // whichever branch that was.
  function automatic void train_row(int row, logic outcome);
    int step;
    int mag;
    step = outcome ? 1 : -1;
    mag  = (last_sum < 0) ? -last_sum : last_sum;
    if ((last_sum >= 0) != outcome || mag <= int'(thr_reg)) begin
      weights[row][0] = clip(weights[row][0] + step);
      for (int i = 0; i < HIST; i++)
        weights[row][i + 1] = clip(weights[row][i + 1] + step * hist_weight(i));
    end
    hist_dir = {outcome, hist_dir[HIST-1:1]};
    hist_val = {1'b1, hist_val[HIST-1:1]};
  endfunction

  function automatic logic predicted_direction(input logic upd, input logic [PC_W-1:0] addr,
                                               input logic signed [OFFSET_W-1:0] off,
                                               input logic outcome);
    int   cidx;
    int   row;
    logic dir;
    cidx = int'(addr % CTR_MOD);
    row  = int'(addr % ROW_MOD);
    dir  = 1'b0;
    if (upd == FUNC_PREDICT) begin
      case (mode_reg)
        MODE_ALWAYS:   dir = 1'b1;
        MODE_BACKWARD: dir = off[OFFSET_W-1];
        MODE_COUNTER:  dir = counters[cidx][1];
        MODE_PERCEPT: begin
          last_sum = row_sum(row);
          dir = (last_sum >= 0);
        end
        default:       dir = 1'b0;
      endcase
    end else if (mode_reg == MODE_COUNTER) begin
      if (outcome && counters[cidx] != CTR_STRONG_T)
        counters[cidx] = counters[cidx] + 2'd1;
      else if (!outcome && counters[cidx] != CTR_STRONG_NT)
        counters[cidx] = counters[cidx] - 2'd1;
    end else if (mode_reg == MODE_PERCEPT) begin
      train_row(row, outcome);
    end
    return dir;
  endfunction

  always @(posedge clk) begin : watch
    direction_t head;
    if (rst) begin
      clear_predictor();
      expected_dirs.delete();
      fail_count = 0;
      checked    = 0;
    end else begin
      // A strobe at this edge always belongs to an item accepted earlier,
      // so the oldest entry is retired before this edge's item is queued.
      if (done) begin
        if (expected_dirs.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("[%0t] direction strobe %b with no item outstanding", $realtime,
                     predict_taken);
        end else begin
          head = expected_dirs[0];
          expected_dirs.delete(0);
          checked++;
          if (predict_taken !== head.dir) begin
            fail_count++;
            if (fail_count <= 10)
              $display("[%0t] %s pc %h: predict_taken expected %b, got %b", $realtime,
                       head.upd == FUNC_UPDATE ? "update" : "predict", head.addr,
                       head.dir, predict_taken);
          end
        end
      end
      // An item taken at this edge still sees the registers as they were.
      if (start && !busy) begin
        head.upd  = func;
        head.addr = pc;
        head.dir  = predicted_direction(func, pc, offset, taken);
        expected_dirs.insert(expected_dirs.size(), head);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MODE:   mode_reg = cfg_data[MODE_W-1:0];
          CFG_THRESH: thr_reg  = cfg_data[THR_W-1:0];
          default:    ;
        endcase
      end
    end
    waiting = expected_dirs.size();
  end

endmodule

FILE: bench/testbench.sv
// Top of the branch direction predictor bench. This module only makes
// stimulus and gives the verdict; prediction and comparison live in the
// checker instance that sits beside the block and watches every channel.
module testbench;
  import bdp_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int CYCLE_LIMIT  = 1_000_000;
  // Perceptron items are the slowest, walking a whole weight row; leave margin.
  localparam int DRAIN_CYCLES = DEF_HISTORY_LEN + 24;
  localparam int ALIAS_BITS   = $clog2(DEF_COUNTER_ENTRIES);
  localparam int LOOP_TRIP    = 7;

  // Outcome patterns for the update beats of a phase.
  localparam int OUT_TAKEN     = 0;
  localparam int OUT_NOT_TAKEN = 1;
  localparam int OUT_COIN      = 2;
  localparam int OUT_LOOP      = 3;

  // Register indexes the block does not implement; writes must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  localparam logic [MODE_W-1:0]          MODE_LAST_CODE = '1;
  localparam logic [THR_W-1:0]           THR_MAX        = '1;
  localparam logic [PC_W-1:0]            PC_MAX         = '1;
  localparam logic [PC_W-1:0]            PC_TOP_BIT     = {1'b1, {(PC_W-1){1'b0}}};
  localparam logic [PC_W-1:0]            PC_ALIAS       = DEF_COUNTER_ENTRIES;
  localparam logic signed [OFFSET_W-1:0] OFF_MIN        = {1'b1, {(OFFSET_W-1){1'b0}}};
  localparam logic signed [OFFSET_W-1:0] OFF_MAX        = {1'b0, {(OFFSET_W-1){1'b1}}};
  localparam logic signed [OFFSET_W-1:0] OFF_NEG_ONE    = '1;

  logic                          clk       = 1'b0;
  logic                          rst       = 1'b1;
  logic                          start     = 1'b0;
  logic                          func      = FUNC_PREDICT;
  logic         [PC_W-1:0]       pc        = '0;
  logic  signed [OFFSET_W-1:0]   offset    = '0;
  logic                          taken     = 1'b0;
  logic                          cfg_valid = 1'b0;
  logic         [CFG_IDX_W-1:0]  cfg_index = CFG_MODE;
  logic         [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                          busy;
  logic                          done;
  logic                          predict_taken;
  logic                          cfg_ready;

  int fail_count;
  int waiting;
  int checked;

  int cycle_count    = 0;
  int items_sent     = 0;
  int directed_items = 0;
  int cfg_beats      = 0;
  int burst_left     = 0;
  int loop_step      = 0;
  bit allow_gaps     = 1'b1;

  branch_direction_predictor DUT (.*);

  bdp_checker scoreboard (.*);

  always #HALF_PERIOD clk = ~clk;

  // Watchdog. The slowest legal run is the reset sweep plus every item at
  // the perceptron latency with the longest sender gap, far below this.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run stopped at cycle %0d with %0d results outstanding.", cycle_count,
               waiting);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Drives one item at a falling edge and holds it until the block takes
  // the beat. When no gap follows, start stays high and the next call simply
  // replaces the fields at the next falling edge. Otherwise the sender goes
  // quiet for a random number of cycles before a new burst begins.
  task automatic issue(input logic f, input logic [PC_W-1:0] p,
                       input logic signed [OFFSET_W-1:0] o, input logic t);
    int gap;
    @(negedge clk);
    func   = f;
    pc     = p;
    offset = o;
    taken  = t;
    start  = 1'b1;
    do @(posedge clk); while (busy);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else if (allow_gaps) begin
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(1, 40);
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Drops start and waits until every issued item has produced its strobe
  // and the block is no longer busy. Also used to absorb the reset sweep.
  task automatic wait_idle();
    @(negedge clk);
    start = 1'b0;
    while (waiting != 0 || busy) @(negedge clk);
  endtask

  // Register writes only ever happen with the block drained.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    wait_idle();
    @(negedge clk);
    cfg_index = idx;
    cfg_data  = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_beats++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic next_outcome(int pattern);
    case (pattern)
      OUT_TAKEN:     return $urandom_range(0, 99) < 95;
      OUT_NOT_TAKEN: return $urandom_range(0, 99) < 5;
      OUT_LOOP: begin
        loop_step++;
        return (loop_step % LOOP_TRIP) != 0;
      end
      default:       return 1'($urandom_range(0, 1));
    endcase
  endfunction

  // One random phase under a fixed mode and threshold. Most of the traffic
  // is a predict followed by the update of the same branch, which is what
  // lets the perceptron actually learn. The rest is stray updates, stray
  // predicts at fully random addresses, and the odd full drain. A narrow
  // phase keeps every address on one counter entry and one weight row,
  // with different upper bits, so that row is trained hard into saturation.
  task automatic run_phase(input logic [MODE_W-1:0] m, input logic [THR_W-1:0] thr,
                           input int count, input int pattern, input bit narrow,
                           input bit gaps);
    logic [PC_W-1:0]       pool [4];
    logic [PC_W-1:0]       addr;
    logic [CFG_DATA_W-1:0] word;
    int                    n;
    int                    roll;
    // Upper data bits are random so the mode decode must ignore them.
    word = CFG_DATA_W'($urandom);
    word[MODE_W-1:0] = m;
    write_reg(CFG_MODE, word);
    write_reg(CFG_THRESH, thr);
    allow_gaps = gaps;
    pool[0] = $urandom;
    for (int j = 1; j < 4; j++) begin
      if (narrow || j == 1)
        pool[j] = ($urandom << ALIAS_BITS) | (pool[0] & (PC_ALIAS - 1));
      else
        pool[j] = $urandom;
    end
    n = 0;
    while (n < count) begin
      roll = $urandom_range(0, 99);
      addr = pool[$urandom_range(0, 3)];
      if (roll < 84) begin
        issue(FUNC_PREDICT, addr, OFFSET_W'($urandom), 1'($urandom));
        issue(FUNC_UPDATE, addr, OFFSET_W'($urandom), next_outcome(pattern));
        n += 2;
      end else if (roll < 92) begin
        issue(FUNC_UPDATE, roll[0] ? addr : PC_W'($urandom), OFFSET_W'($urandom),
              1'($urandom));
        n++;
      end else if (roll < 99) begin
        issue(FUNC_PREDICT, $urandom, OFFSET_W'($urandom), 1'($urandom));
        n++;
      end else begin
        // The sender holds off until everything outstanding has come back.
        wait_idle();
      end
    end
  endtask

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] word;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    // The block sweeps both tables after reset with busy held high.
    wait_idle();

    // Counter mode is the reset mode, and every counter starts weakly taken.
    issue(FUNC_PREDICT, '0, '0, 1'b0);
    issue(FUNC_UPDATE, '0, '0, 1'b0);
    issue(FUNC_PREDICT, '0, OFF_MIN, 1'b1);
    // Two more not-taken outcomes: reach strong not taken, then hold at the floor.
    repeat (2) issue(FUNC_UPDATE, '0, '0, 1'b0);
    // Three taken outcomes climb to strong taken and stick at the ceiling.
    repeat (3) issue(FUNC_UPDATE, PC_MAX, OFF_MAX, 1'b1);
    issue(FUNC_PREDICT, PC_MAX, OFF_MAX, 1'b0);
    // An address that differs only above the index bits shares entry zero.
    issue(FUNC_PREDICT, PC_ALIAS, OFF_MAX, 1'b1);

    // Static modes; the update in never-taken mode must still answer zero.
    write_reg(CFG_MODE, CFG_DATA_W'(MODE_NEVER));
    issue(FUNC_PREDICT, PC_MAX, OFF_MIN, 1'b1);
    issue(FUNC_UPDATE, PC_MAX, OFF_MIN, 1'b1);
    write_reg(CFG_MODE, CFG_DATA_W'(MODE_ALWAYS));
    issue(FUNC_PREDICT, '0, OFF_MAX, 1'b0);
    // Backward-taken looks only at the sign of the offset.
    write_reg(CFG_MODE, CFG_DATA_W'(MODE_BACKWARD));
    issue(FUNC_PREDICT, PC_TOP_BIT, OFF_MIN, 1'b0);
    issue(FUNC_PREDICT, PC_TOP_BIT, OFF_MAX, 1'b1);
    issue(FUNC_PREDICT, PC_TOP_BIT, '0, 1'b1);
    issue(FUNC_PREDICT, PC_TOP_BIT, OFF_NEG_ONE, 1'b0);

    // Perceptron with a zero margin. The first update comes with no predict
    // before it, so it trains against the zero sum held since reset.
    write_reg(CFG_MODE, CFG_DATA_W'(MODE_PERCEPT));
    write_reg(CFG_THRESH, '0);
    issue(FUNC_UPDATE, PC_TOP_BIT, '0, 1'b0);
    issue(FUNC_PREDICT, PC_TOP_BIT, '0, 1'b1);
    issue(FUNC_UPDATE, PC_TOP_BIT, '0, 1'b1);
    // Address zero lands on the same weight row as the top-bit address.
    issue(FUNC_PREDICT, '0, OFF_MIN, 1'b0);

    // Writes to indexes with no register behind them change nothing.
    write_reg(CFG_SPARE_A, '1);
    write_reg(CFG_SPARE_B, '0);
    issue(FUNC_PREDICT, PC_TOP_BIT, OFF_MAX, 1'b0);

    // Unused mode codes answer zero and leave the tables alone.
    word = '1;
    word[MODE_W-1:0] = MODE_PERCEPT + 1'b1;
    write_reg(CFG_MODE, word);
    issue(FUNC_PREDICT, '0, OFF_NEG_ONE, 1'b1);
    issue(FUNC_UPDATE, '0, OFF_NEG_ONE, 1'b1);
    write_reg(CFG_MODE, CFG_DATA_W'(MODE_LAST_CODE));
    issue(FUNC_PREDICT, PC_MAX, OFF_MIN, 1'b1);
    directed_items = items_sent;

    // Random phases. The two narrow perceptron phases with the largest
    // margin train on every update, driving one row to each weight limit.
    run_phase(MODE_PERCEPT, THR_MAX, 350, OUT_TAKEN, 1'b1, 1'b1);
    run_phase(MODE_COUNTER, THR_RESET, 150, OUT_COIN, 1'b0, 1'b0);
    run_phase(MODE_PERCEPT, THR_MAX, 350, OUT_NOT_TAKEN, 1'b1, 1'b0);
    run_phase(MODE_BACKWARD, THR_W'($urandom), 100, OUT_COIN, 1'b0, 1'b1);
    run_phase(MODE_ALWAYS, '0, 60, OUT_COIN, 1'b0, 1'b1);
    run_phase(MODE_NEVER, THR_MAX, 60, OUT_COIN, 1'b0, 1'b0);
    // A zero margin trains only on mispredictions and on a zero sum.
    run_phase(MODE_PERCEPT, '0, 150, OUT_COIN, 1'b0, 1'b1);
    run_phase(MODE_COUNTER, THR_W'($urandom), 150, OUT_TAKEN, 1'b0, 1'b1);
    run_phase(MODE_W'($urandom_range(MODE_PERCEPT + 1, MODE_LAST_CODE)), THR_W'($urandom),
              60, OUT_COIN, 1'b0, 1'b1);
    // A loop-shaped pattern gives the global history something to learn.
    run_phase(MODE_PERCEPT, THR_RESET, 200, OUT_LOOP, 1'b0, 1'b1);
    run_phase(MODE_PERCEPT, THR_W'($urandom), 150, OUT_COIN, 1'b1, 1'b0);
    run_phase(MODE_COUNTER, THR_W'($urandom), 60, OUT_NOT_TAKEN, 1'b0, 1'b1);

    // Drain, then give any stray strobe a chance to show up.
    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Covered %0d items (%0d directed) over all five modes, unused mode codes",
             items_sent, directed_items);
    $display("and margins 0 to %0d, with %0d register beats; %0d strobes compared.",
             THR_MAX, cfg_beats, checked);
    if (fail_count == 0 && waiting == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results never arrived.", fail_count, waiting);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/bdp_pkg.sv
hdl/branch_direction_predictor.sv
bench/bdp_checker.sv
bench/testbench.sv
